// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the SHA-256 digest block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define SHA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sha256md: same-cycle check failed");

// Property whose consequence must hold in the cycle after its antecedent.
`define SHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sha256md: next-cycle check failed");

`endif

// File: rtl/sha256md_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256md_pkg
// Types, constants and helper functions shared by the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha256md_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_PAD2,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL
  } state_e;

  // Commands from the sequencer to the block buffer and message schedule.
  typedef struct packed {
    logic        wr_byte;
    logic        pad;
    logic        put_len;
    logic        len_only;
    logic        shift;
    logic [5:0]  idx;
    logic [7:0]  data;
    logic [63:0] bit_len;
  } sched_cmd_t;

  // Commands from the sequencer to the round unit.
  typedef struct packed {
    logic       load;
    logic       round;
    logic       final_add;
    logic       restart;
    logic [5:0] rnd;
  } round_cmd_t;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenSlot  = 6'd56;
  localparam logic [5:0] LastRnd  = 6'd63;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: rtl/sha256_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 digest of a byte stream, one message byte per item, using one
// shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                        Payload
//   s_axis    in         s_axis_tvalid_i / s_axis_tready_o data byte, present flag, end flag
//   m_axis    out        m_axis_tvalid_o / m_axis_tready_i 256-bit digest as four 64-bit words
//
// A byte that does not complete a 64-byte block is taken at once; one that does holds off
// the input for a load, 64 rounds of the shared round unit and a chaining add.
// Closing a message adds a padding step and a block pass, twice when 56+ bytes are in use.
// Reset is asynchronous and active low; it restores the initial hash values and counters.
// The digest waits in an output register while new input is taken; a second digest
// stalls its final add, and with it the input, until the first one has been taken.
// ----------------------------------------------------------------------------
module sha256_message_digest (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,  // [7:0] data_byte
  input  logic         s_axis_tuser_i,  // [0] byte_present
  input  logic         s_axis_tlast_i,  // end_of_message
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [255:0] m_axis_tdata_o   // [63:0] digest_high, [127:64] digest_upper_mid,
                                        // [191:128] digest_lower_mid, [255:192] digest_low
);
  import sha256md_pkg::*;

  sched_cmd_t      sched_cmd;
  round_cmd_t      round_cmd;
  logic [31:0]     w_cur;
  logic [7:0][31:0] sum;
  logic            emit;
  logic            out_busy;
  logic            out_valid_q, out_valid_d;
  logic [255:0]    out_data_q, out_data_d;

  assign out_busy = out_valid_q && !m_axis_tready_i;

  sha256md_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_data_i    (s_axis_tdata_i),
    .in_present_i (s_axis_tuser_i),
    .in_last_i    (s_axis_tlast_i),
    .out_busy_i   (out_busy),
    .in_ready_o   (s_axis_tready_o),
    .emit_o       (emit),
    .sched_cmd_o  (sched_cmd),
    .round_cmd_o  (round_cmd)
  );

  sha256md_sched u_sched (
    .clk_i (clk_i),
    .cmd_i (sched_cmd),
    .w_o   (w_cur)
  );

  sha256md_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (round_cmd),
    .w_i    (w_cur),
    .sum_o  (sum)
  );

  // The final sums are captured here, H0 in the top half of the lowest word.
  always_comb begin
    out_valid_d = emit || out_busy;
    out_data_d  = out_data_q;
    if (emit) begin
      out_data_d = {sum[6], sum[7], sum[4], sum[5], sum[2], sum[3], sum[0], sum[1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// File: rtl/sha256md_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256md_sched
// Block buffer of sixteen words that doubles as the message schedule window.
// ----------------------------------------------------------------------------
module sha256md_sched (
  input  logic                    clk_i,
  input  sha256md_pkg::sched_cmd_t cmd_i,
  output logic [31:0]             w_o
);
  import sha256md_pkg::*;

  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [31:0] s0;
  logic [31:0] s1;
  logic [31:0] w_new;

  assign s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_new = s1 + w_q[9] + s0 + w_q[0];
  assign w_o   = w_q[0];

  always_comb begin
    w_d = w_q;
    if (cmd_i.shift) begin
      for (int j = 0; j < 15; j++) begin
        w_d[j] = w_q[j + 1];
      end
      w_d[15] = w_new;
    end
    // Bytes fill each word from its most significant lane down.
    if (cmd_i.wr_byte) begin
      w_d[cmd_i.idx[5:2]][{~cmd_i.idx[1:0], 3'b000} +: 8] = cmd_i.data;
    end
    if (cmd_i.pad) begin
      for (int p = 0; p < 64; p++) begin
        if (6'(p) == cmd_i.idx) begin
          w_d[p / 4][(3 - (p % 4)) * 8 +: 8] = PadByte;
        end else if (6'(p) > cmd_i.idx) begin
          w_d[p / 4][(3 - (p % 4)) * 8 +: 8] = 8'h00;
        end
      end
    end
    if (cmd_i.len_only) begin
      w_d = '{default: '0};
    end
    if (cmd_i.put_len || cmd_i.len_only) begin
      w_d[14] = cmd_i.bit_len[63:32];
      w_d[15] = cmd_i.bit_len[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

endmodule

// File: rtl/sha256md_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256md_round
// Shared round unit: working variables, chaining words and the final add.
// ----------------------------------------------------------------------------
module sha256md_round (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sha256md_pkg::round_cmd_t cmd_i,
  input  logic [31:0]             w_i,
  output logic [7:0][31:0]        sum_o
);
  import sha256md_pkg::*;

  logic [31:0] chain_q [8];
  logic [31:0] chain_d [8];
  logic [31:0] work_q  [8];
  logic [31:0] work_d  [8];
  logic [31:0] big0;
  logic [31:0] big1;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  assign big1 = rotr(work_q[4], 6) ^ rotr(work_q[4], 11) ^ rotr(work_q[4], 25);
  assign ch   = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
  assign t1   = work_q[7] + big1 + ch + RoundK[cmd_i.rnd] + w_i;
  assign big0 = rotr(work_q[0], 2) ^ rotr(work_q[0], 13) ^ rotr(work_q[0], 22);
  assign maj  = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
  assign t2   = big0 + maj;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sum_o[i] = chain_q[i] + work_q[i];
    end
  end

  always_comb begin
    work_d  = work_q;
    chain_d = chain_q;
    if (cmd_i.load) begin
      work_d = chain_q;
    end
    if (cmd_i.round) begin
      work_d[7] = work_q[6];
      work_d[6] = work_q[5];
      work_d[5] = work_q[4];
      work_d[4] = work_q[3] + t1;
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[0];
      work_d[0] = t1 + t2;
    end
    if (cmd_i.final_add) begin
      if (cmd_i.restart) begin
        chain_d = InitH;
      end else begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = sum_o[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= InitH;
    end else begin
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

endmodule

// File: rtl/sha256md_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256md_ctrl
// Sequencer: byte counting, padding steps and the 64-round schedule.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha256md_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [7:0]               in_data_i,
  input  logic                     in_present_i,
  input  logic                     in_last_i,
  input  logic                     out_busy_i,
  output logic                     in_ready_o,
  output logic                     emit_o,
  output sha256md_pkg::sched_cmd_t sched_cmd_o,
  output sha256md_pkg::round_cmd_t round_cmd_o
);
  import sha256md_pkg::*;

  state_e      st_q, st_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] cnt_q, cnt_d;
  logic        fin_q, fin_d;
  logic        last_q, last_d;
  logic        extra_q, extra_d;

  // Next state.
  always_comb begin
    st_d    = st_q;
    rnd_d   = rnd_q;
    fill_d  = fill_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    last_d  = last_q;
    extra_d = extra_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_present_i) begin
            fill_d = fill_q + 6'd1;
            cnt_d  = cnt_q + 61'd1;
          end
          fin_d   = in_last_i;
          last_d  = 1'b0;
          extra_d = 1'b0;
          if (in_present_i && (&fill_q)) begin
            st_d = ST_LOAD;
          end else if (in_last_i) begin
            st_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_q >= LenSlot) begin
          extra_d = 1'b1;
        end else begin
          last_d = 1'b1;
        end
        st_d = ST_LOAD;
      end
      ST_PAD2: begin
        extra_d = 1'b0;
        last_d  = 1'b1;
        st_d    = ST_LOAD;
      end
      ST_LOAD: begin
        rnd_d = '0;
        st_d  = ST_ROUND;
      end
      ST_ROUND: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == LastRnd) begin
          st_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (last_q) begin
          if (!out_busy_i) begin
            st_d   = ST_IDLE;
            fill_d = '0;
            cnt_d  = '0;
            fin_d  = 1'b0;
            last_d = 1'b0;
          end
        end else if (extra_q) begin
          st_d = ST_PAD2;
        end else if (fin_q) begin
          st_d = ST_PAD;
        end else begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    sched_cmd_o         = '0;
    sched_cmd_o.idx     = fill_q;
    sched_cmd_o.data    = in_data_i;
    sched_cmd_o.bit_len = {cnt_q, 3'b000};
    round_cmd_o         = '0;
    round_cmd_o.rnd     = rnd_q;
    in_ready_o          = 1'b0;
    emit_o              = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        in_ready_o          = 1'b1;
        sched_cmd_o.wr_byte = in_valid_i && in_present_i;
      end
      ST_PAD: begin
        sched_cmd_o.pad     = 1'b1;
        sched_cmd_o.put_len = (fill_q < LenSlot);
      end
      ST_PAD2: begin
        sched_cmd_o.len_only = 1'b1;
      end
      ST_LOAD: begin
        round_cmd_o.load = 1'b1;
      end
      ST_ROUND: begin
        round_cmd_o.round = 1'b1;
        sched_cmd_o.shift = 1'b1;
      end
      ST_FINAL: begin
        round_cmd_o.final_add = !(last_q && out_busy_i);
        round_cmd_o.restart   = last_q;
        emit_o                = last_q && !out_busy_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      rnd_q   <= '0;
      fill_q  <= '0;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
      last_q  <= 1'b0;
      extra_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      rnd_q   <= rnd_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      last_q  <= last_d;
      extra_q <= extra_d;
    end
  end

  `SHA_ASSERT_NEXT(a_round_to_final, clk_i, rst_ni, st_q == ST_ROUND && rnd_q == LastRnd, st_q == ST_FINAL)
  `SHA_ASSERT_NEXT(a_emit_clears, clk_i, rst_ni, emit_o, st_q == ST_IDLE && fill_q == '0 && cnt_q == '0)
  `SHA_ASSERT_NEXT(a_extra_block, clk_i, rst_ni, st_q == ST_FINAL && extra_q, st_q == ST_PAD2 && last_q == 1'b0)
  `SHA_ASSERT_NOW(a_emit_last_only, clk_i, rst_ni, emit_o, last_q && st_q == ST_FINAL && !fin_q == 1'b0)

endmodule
